@@ rtl/sses_pkg.sv @@
package sses_pkg;

    localparam int MAX_STATES  = 8;
    localparam int MAX_INPUTS  = 8;
    localparam int MAX_OUTPUTS = 8;
    localparam int FRAC_BITS   = 16;

    localparam int IDX_W      = 3;
    localparam int COUNT_W    = 4;
    localparam int VAL_W      = 32;
    localparam int SEL_W      = 2;
    localparam int MODE_W     = 2;

    localparam int IN_ROW_LSB = 0;
    localparam int IN_COL_LSB = IN_ROW_LSB + IDX_W;
    localparam int IN_VAL_LSB = IN_COL_LSB + IDX_W;
    localparam int S_TDATA_W  = ((IN_VAL_LSB + VAL_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = MODE_W + SEL_W;
    localparam int M_TDATA_W  = ((IDX_W + VAL_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - IDX_W - VAL_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int COEF_AW    = SEL_W + 2 * IDX_W;
    localparam int COEF_DEPTH = 1 << COEF_AW;

    localparam int OPER_W     = VAL_W + 1;
    localparam int PROD_W     = 2 * OPER_W;
    localparam int ACC_W      = 56;

    typedef enum logic [MODE_W-1:0] {
        MODE_COEF  = 2'd0,
        MODE_STATE = 2'd1,
        MODE_INPUT = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [SEL_W-1:0] {
        MAT_A = 2'd0,
        MAT_B = 2'd1,
        MAT_C = 2'd2,
        MAT_D = 2'd3
    } mat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATE_COUNT  = 2'd0,
        CFG_INPUT_COUNT  = 2'd1,
        CFG_OUTPUT_COUNT = 2'd2,
        CFG_STEP_SIZE    = 2'd3
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } seq_t;

    typedef enum logic [1:0] {
        PH_OUT,
        PH_DER,
        PH_UPD
    } phase_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            hi = {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
            lo = {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
            if (v > hi)
                return hi[VAL_W-1:0];
            else if (v < lo)
                return lo[VAL_W-1:0];
            else
                return v[VAL_W-1:0];
        end
    endfunction

    function automatic logic [IDX_W-1:0] last_index(input logic [COUNT_W-1:0] c,
                                                   input int max_count);
        logic [COUNT_W-1:0] m;
        begin
            m = COUNT_W'(max_count);
            if (c == '0)
                return '0;
            else if (c > m)
                return IDX_W'(m - 1'b1);
            else
                return IDX_W'(c - 1'b1);
        end
    endfunction

endpackage

@@ rtl/sses_ram.sv @@
module sses_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/state_space_euler_step_core.sv @@
// Linear state-space model advanced by forward Euler, signed Q16.16.
// Input channel s_*: one beat per command. Load a coefficient of A, B, C
// or D, write a state element, clear the state, or deliver an element of u.
// Every command except the last input element leaves the block ready again
// in the next cycle.
// The input element at index input_count-1 (0 for a count of 0, 7 above 8)
// starts a step: y = Cx + Du goes out on m_* one element per beat with
// m_tlast on the final one, then x = x + Ts(Ax + Bu) is applied; s_tready
// stays low until the state is written back.
// All products run through one 33x33 multiplier, one term per cycle while a
// row issues, over a three-stage issue/multiply/accumulate pipe; a row of
// C|D or A|B holds ns+ni terms, an update row one term.
// Output beats sit in an output register; a stalled receiver holds the
// beat and halts the row sequencer until the beat is taken.
// Reset clears the state vector and all coefficients (via per-entry valid
// bits) and sets counts to 1, step size to 1.0; input elements stay undefined
// until written. Configuration must be written only while idle; not enforced.
module state_space_euler_step_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // row_index, col_index, value, zero pad
    input  logic [sses_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode, matrix_select
    input  logic [sses_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_index, out_value, zero pad
    output logic [sses_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [sses_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sses_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sses_pkg::*;

    logic [COUNT_W-1:0]        state_count_reg;
    logic [COUNT_W-1:0]        input_count_reg;
    logic [COUNT_W-1:0]        output_count_reg;
    logic [VAL_W-1:0]          step_size_reg;

    seq_t                      seq_reg, seq_next;
    phase_t                    phase_reg, phase_next;
    logic [IDX_W-1:0]          row_reg, row_next;
    logic [IDX_W-1:0]          col_reg, col_next;
    logic                      part_reg, part_next;
    logic                      p1_valid_reg, p1_valid_next;
    logic                      p2_valid_reg, p2_valid_next;
    logic                      upd_reg, upd_next;
    logic                      cval_reg, cval_next;
    logic signed [OPER_W-1:0]  vec_reg, vec_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic [COEF_DEPTH-1:0]     coef_vld_reg, coef_vld_next;
    logic signed [VAL_W-1:0]   xvec_reg [MAX_STATES];
    logic signed [VAL_W-1:0]   xvec_next [MAX_STATES];
    logic signed [VAL_W-1:0]   ubuf_reg [MAX_INPUTS];
    logic signed [VAL_W-1:0]   ubuf_next [MAX_INPUTS];
    logic signed [VAL_W-1:0]   deriv_reg [MAX_STATES];
    logic signed [VAL_W-1:0]   deriv_next [MAX_STATES];

    logic                      out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]          out_index_reg, out_index_next;
    logic signed [VAL_W-1:0]   out_value_reg, out_value_next;
    logic                      out_last_reg, out_last_next;

    logic                      ram_we;
    logic [COEF_AW-1:0]        ram_waddr;
    logic [COEF_AW-1:0]        ram_raddr;
    logic [VAL_W-1:0]          ram_rdata;

    logic                      s_accept;
    logic                      out_free;
    mode_t                     in_mode;
    logic [SEL_W-1:0]          in_sel;
    logic [IDX_W-1:0]          in_row;
    logic [IDX_W-1:0]          in_col;
    logic signed [VAL_W-1:0]   in_value;
    logic [IDX_W-1:0]          ns_last;
    logic [IDX_W-1:0]          ni_last;
    logic [IDX_W-1:0]          no_last;
    mat_t                      issue_mat;
    logic signed [OPER_W-1:0]  opa;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [PROD_W-1:0]  prod_shift;
    logic signed [ACC_W-1:0]   sum_upd;
    logic signed [VAL_W-1:0]   acc_sat;

    assign in_mode  = mode_t'(s_tuser[MODE_W-1:0]);
    assign in_sel   = s_tuser[MODE_W +: SEL_W];
    assign in_row   = s_tdata[IN_ROW_LSB +: IDX_W];
    assign in_col   = s_tdata[IN_COL_LSB +: IDX_W];
    assign in_value = s_tdata[IN_VAL_LSB +: VAL_W];

    assign ns_last = last_index(state_count_reg, MAX_STATES);
    assign ni_last = last_index(input_count_reg, MAX_INPUTS);
    assign no_last = last_index(output_count_reg, MAX_OUTPUTS);

    assign s_tready = (seq_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        case (phase_reg)
            PH_OUT:  issue_mat = part_reg ? MAT_D : MAT_C;
            PH_DER:  issue_mat = part_reg ? MAT_B : MAT_A;
            default: issue_mat = MAT_A;
        endcase
    end

    assign ram_raddr = {issue_mat, row_reg, col_reg};
    assign ram_waddr = {in_sel, in_row, in_col};

    sses_ram #(
        .WIDTH (VAL_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // multiplier operand A: step size for the update, else coefficient (zero if never loaded)
    always_comb
    begin
        if (upd_reg)
            opa = {1'b0, step_size_reg};
        else if (cval_reg)
            opa = {ram_rdata[VAL_W-1], ram_rdata};
        else
            opa = '0;
    end

    assign prod_next  = opa * vec_reg;
    assign prod_rnd   = prod_reg + (PROD_W'(1) <<< (FRAC_BITS - 1));
    assign prod_shift = prod_rnd >>> FRAC_BITS;
    assign acc_sat    = sat32(acc_reg);
    assign sum_upd    = acc_reg + ACC_W'(xvec_reg[row_reg]);

    always_comb
    begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        part_next      = part_reg;
        p1_valid_next  = 1'b0;
        p2_valid_next  = p1_valid_reg;
        upd_next       = upd_reg;
        cval_next      = cval_reg;
        vec_next       = vec_reg;
        acc_next       = p2_valid_reg ? acc_reg + prod_shift[ACC_W-1:0] : acc_reg;
        coef_vld_next  = coef_vld_reg;
        xvec_next      = xvec_reg;
        ubuf_next      = ubuf_reg;
        deriv_next     = deriv_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;

        case (seq_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_mode)
                        MODE_COEF:
                        begin
                            ram_we                   = 1'b1;
                            coef_vld_next[ram_waddr] = 1'b1;
                        end
                        MODE_STATE:
                        begin
                            xvec_next[in_row] = in_value;
                        end
                        MODE_INPUT:
                        begin
                            ubuf_next[in_col] = in_value;
                            if (in_col == ni_last)
                            begin
                                seq_next   = ST_ISSUE;
                                phase_next = PH_OUT;
                                row_next   = '0;
                                col_next   = '0;
                                part_next  = 1'b0;
                                acc_next   = '0;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            for (int k = 0; k < MAX_STATES; k++)
                            begin
                                xvec_next[k] = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ISSUE:
            begin
                p1_valid_next = 1'b1;
                upd_next      = (phase_reg == PH_UPD);
                cval_next     = coef_vld_reg[ram_raddr];
                if (phase_reg == PH_UPD)
                begin
                    vec_next = OPER_W'(deriv_reg[row_reg]);
                    seq_next = ST_WAIT;
                end
                else if (!part_reg)
                begin
                    vec_next = OPER_W'(xvec_reg[col_reg]);
                    if (col_reg == ns_last)
                    begin
                        part_next = 1'b1;
                        col_next  = '0;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                else
                begin
                    vec_next = OPER_W'(ubuf_reg[col_reg]);
                    if (col_reg == ni_last)
                        seq_next = ST_WAIT;
                    else
                        col_next = col_reg + 1'b1;
                end
            end

            ST_WAIT:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    case (phase_reg)
                        PH_OUT:
                        begin
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                out_index_next = row_reg;
                                out_value_next = acc_sat;
                                out_last_next  = (row_reg == no_last);
                                seq_next       = ST_ISSUE;
                                col_next       = '0;
                                part_next      = 1'b0;
                                acc_next       = '0;
                                if (row_reg == no_last)
                                begin
                                    phase_next = PH_DER;
                                    row_next   = '0;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                        end
                        PH_DER:
                        begin
                            deriv_next[row_reg] = acc_sat;
                            seq_next            = ST_ISSUE;
                            col_next            = '0;
                            part_next           = 1'b0;
                            acc_next            = '0;
                            if (row_reg == ns_last)
                            begin
                                phase_next = PH_UPD;
                                row_next   = '0;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        PH_UPD:
                        begin
                            xvec_next[row_reg] = sat32(sum_upd);
                            acc_next           = '0;
                            if (row_reg == ns_last)
                            begin
                                seq_next = ST_IDLE;
                            end
                            else
                            begin
                                seq_next = ST_ISSUE;
                                row_next = row_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            seq_next = ST_IDLE;
                        end
                    endcase
                end
            end

            default:
            begin
                seq_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg  <= COUNT_W'(1);
            input_count_reg  <= COUNT_W'(1);
            output_count_reg <= COUNT_W'(1);
            step_size_reg    <= VAL_W'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_t'(cfg_index))
                CFG_STATE_COUNT:  state_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_INPUT_COUNT:  input_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_OUTPUT_COUNT: output_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_STEP_SIZE:    step_size_reg    <= cfg_data[VAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= ST_IDLE;
            phase_reg     <= PH_OUT;
            row_reg       <= '0;
            col_reg       <= '0;
            part_reg      <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            upd_reg       <= 1'b0;
            cval_reg      <= 1'b0;
            coef_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int k = 0; k < MAX_STATES; k++)
            begin
                xvec_reg[k] <= '0;
            end
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            part_reg      <= part_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            upd_reg       <= upd_next;
            cval_reg      <= cval_next;
            coef_vld_reg  <= coef_vld_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            xvec_reg      <= xvec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg       <= vec_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        ubuf_reg      <= ubuf_next;
        deriv_reg     <= deriv_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
    end

endmodule

@@ rtl/sses_checker.sv @@
module sses_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [sses_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [sses_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sses_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    import sses_pkg::*;

    logic s_beat;
    logic m_beat;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    a_quick_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat && (s_tuser[MODE_W-1:0] == MODE_COEF || s_tuser[MODE_W-1:0] == MODE_STATE ||
                   s_tuser[MODE_W-1:0] == MODE_CLEAR)
        |=> s_tready)
        else $error("single-cycle command left the block busy");

    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("output beat appeared while idle");

    a_mid_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_beat && !m_tlast |-> !s_tready)
        else $error("block idle before last output of a step");

endmodule

bind state_space_euler_step_core sses_checker u_sses_checker (.*);

@@ bench/state_space_euler_step_core_tb.sv @@
module state_space_euler_step_core_tb;

    import sses_pkg::*;

    localparam int HOLD_OFF_CYCLES = 600;
    localparam int SETTLE_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_ITEMS     = 47;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             last;
    } ss_beat_t;

    class ss_model_checker;
        logic signed [VAL_W-1:0] coef [4][MAX_STATES][MAX_STATES];
        logic signed [VAL_W-1:0] xvec [MAX_STATES];
        logic signed [VAL_W-1:0] ubuf [MAX_INPUTS];
        logic [COUNT_W-1:0]      n_state;
        logic [COUNT_W-1:0]      n_input;
        logic [COUNT_W-1:0]      n_output;
        logic [31:0]             ts;
        ss_beat_t                pending_outputs [$];
        int                      errors;
        int                      steps;
        int                      beats;

        function new();
            foreach (coef[m, r, c])
                coef[m][r][c] = '0;
            foreach (xvec[i])
                xvec[i] = '0;
            foreach (ubuf[i])
                ubuf[i] = '0;
            n_state  = 4'd1;
            n_input  = 4'd1;
            n_output = 4'd1;
            ts       = 32'h0001_0000;
            errors   = 0;
            steps    = 0;
            beats    = 0;
        endfunction

        function void report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endfunction

        function int clamp_count(logic [COUNT_W-1:0] c, int max_n);
            if (c == '0)
                return 1;
            if (int'(c) > max_n)
                return max_n;
            return int'(c);
        endfunction

        function int used_states();
            return clamp_count(n_state, MAX_STATES);
        endfunction

        function int used_inputs();
            return clamp_count(n_input, MAX_INPUTS);
        endfunction

        function int used_outputs();
            return clamp_count(n_output, MAX_OUTPUTS);
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        function logic signed [127:0] mul_rnd(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [127:0] aw;
            logic signed [127:0] bw;
            logic signed [127:0] p;
            aw = a;
            bw = b;
            p  = aw * bw;
            return (p + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        endfunction

        function logic signed [VAL_W-1:0] sat_word(logic signed [127:0] v);
            if (v > 128'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (v < -128'sd2147483648)
                return 32'sh8000_0000;
            return v[VAL_W-1:0];
        endfunction

        function void set_config(cfg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STATE_COUNT:  n_state  = data[COUNT_W-1:0];
                CFG_INPUT_COUNT:  n_input  = data[COUNT_W-1:0];
                CFG_OUTPUT_COUNT: n_output = data[COUNT_W-1:0];
                CFG_STEP_SIZE:    ts       = data;
                default:          ;
            endcase
        endfunction

        // y = Cx + Du, then x = x + Ts(Ax + Bu), all from the old state
        function void euler_step();
            int                      ns;
            int                      ni;
            int                      no;
            logic signed [127:0]     acc;
            logic signed [VAL_W-1:0] deriv [MAX_STATES];
            ss_beat_t                b;
            ns = used_states();
            ni = used_inputs();
            no = used_outputs();
            steps++;
            for (int i = 0; i < no; i++)
            begin
                acc = '0;
                for (int j = 0; j < ns; j++)
                    acc += mul_rnd(coef[int'(MAT_C)][i][j], xvec[j]);
                for (int j = 0; j < ni; j++)
                    acc += mul_rnd(coef[int'(MAT_D)][i][j], ubuf[j]);
                b.idx  = 3'(i);
                b.val  = sat_word(acc);
                b.last = (i == no - 1);
                pending_outputs.push_back(b);
            end
            for (int i = 0; i < ns; i++)
            begin
                acc = '0;
                for (int j = 0; j < ns; j++)
                    acc += mul_rnd(coef[int'(MAT_A)][i][j], xvec[j]);
                for (int j = 0; j < ni; j++)
                    acc += mul_rnd(coef[int'(MAT_B)][i][j], ubuf[j]);
                deriv[i] = sat_word(acc);
            end
            for (int i = 0; i < ns; i++)
                xvec[i] = sat_word(xvec[i] + mul_rnd($signed({32'b0, ts}), deriv[i]));
        endfunction

        function void note_beat(mode_t m, mat_t sel, logic [IDX_W-1:0] row,
                                logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] v);
            case (m)
                MODE_COEF:  coef[int'(sel)][row][col] = v;
                MODE_STATE: xvec[row] = v;
                MODE_CLEAR:
                begin
                    foreach (xvec[i])
                        xvec[i] = '0;
                end
                default:
                begin
                    ubuf[col] = v;
                    if (int'(col) == used_inputs() - 1)
                        euler_step();
                end
            endcase
        endfunction

        function void check_output(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val, logic last);
            ss_beat_t exp_b;
            beats++;
            if (pending_outputs.size() == 0)
            begin
                report($sformatf("unexpected output beat, index %0d value %h last %b",
                                 idx, val, last));
                return;
            end
            exp_b = pending_outputs.pop_front();
            if (idx !== exp_b.idx)
                report($sformatf("step %0d out_index got %0d expected %0d",
                                 steps, idx, exp_b.idx));
            if (val !== exp_b.val)
                report($sformatf("step %0d out_value[%0d] got %h expected %h",
                                 steps, exp_b.idx, val, exp_b.val));
            if (last !== exp_b.last)
                report($sformatf("step %0d last_output[%0d] got %b expected %b",
                                 steps, exp_b.idx, last, exp_b.last));
        endfunction

        function void drain_check();
            if (pending_outputs.size() != 0)
                report($sformatf("%0d expected output beats never arrived",
                                 pending_outputs.size()));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ss_model_checker sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    bit              pressure_on;
    int              items_sent;

    state_space_euler_step_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // receiver: random stalls, plus one long hold-off when pressure is requested
    initial
    begin
        int held;
        held     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_on && held < HOLD_OFF_CYCLES)
            begin
                m_tready = 1'b0;
                held++;
            end
            else
                m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_output(m_tdata[IDX_W-1:0], m_tdata[IDX_W +: VAL_W], m_tlast);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(5))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h0000_8000;
                    default: return 32'hFFFF_8000;
                endcase
            end
            default: return $urandom_range(0, 1 << 19) - (1 << 18);
        endcase
    endfunction

    function automatic int pick_index(int n);
        if ($urandom_range(3) == 0)
            return $urandom_range(7);
        return $urandom_range(n - 1);
    endfunction

    task automatic send_beat(mode_t m, mat_t sel, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic [VAL_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata                         = '0;
        s_tdata[IN_ROW_LSB +: IDX_W]    = row;
        s_tdata[IN_COL_LSB +: IDX_W]    = col;
        s_tdata[IN_VAL_LSB +: VAL_W]    = v;
        s_tuser[MODE_W-1:0]             = m;
        s_tuser[MODE_W +: SEL_W]        = sel;
        s_tvalid                        = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(m, sel, row, col, v);
        items_sent++;
    endtask

    task automatic write_cfg(cfg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.set_config(idx, data);
    endtask

    // hold until every expected beat is back and the state write-back is over
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_sequence();
        int   ns;
        int   ni;
        int   no;
        int   n_pre;
        int   stop_at;
        mat_t sel;
        ns = sb.used_states();
        ni = sb.used_inputs();
        no = sb.used_outputs();
        if ($urandom_range(3) == 0)
        begin
            send_beat(mode_t'($urandom_range(3)), mat_t'($urandom_range(3)),
                      $urandom_range(7), $urandom_range(7), rand_value());
            return;
        end
        n_pre = $urandom_range(0, 4);
        repeat (n_pre)
        begin
            sel = mat_t'($urandom_range(3));
            if ($urandom_range(3) != 0)
                send_beat(MODE_COEF, sel, pick_index(sel[1] ? no : ns),
                          pick_index(sel[0] ? ni : ns), rand_value());
            else
                send_beat(MODE_STATE, sel, pick_index(ns), $urandom_range(7), rand_value());
        end
        if ($urandom_range(9) == 0)
            send_beat(MODE_CLEAR, mat_t'($urandom_range(3)), $urandom_range(7),
                      $urandom_range(7), $urandom);
        // broken sequence: stop short of the element that starts a step
        stop_at = ($urandom_range(6) == 0) ? $urandom_range(ni - 1) : ni;
        for (int c = 0; c < stop_at; c++)
            send_beat(MODE_INPUT, mat_t'($urandom_range(3)), $urandom_range(7), c, rand_value());
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] cs;
        logic [CFG_DATA_W-1:0] ci;
        logic [CFG_DATA_W-1:0] co;
        logic [CFG_DATA_W-1:0] step;
        int                    start;

        sb             = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_STATE_COUNT;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_on    = 1'b0;
        items_sent     = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every input element first; element 0 starts a step at reset counts
        send_beat(MODE_INPUT, MAT_D, 3'd7, 3'd7, 32'h7FFF_FFFF);
        send_beat(MODE_INPUT, MAT_A, 3'd0, 3'd6, 32'h8000_0000);
        for (int c = 5; c > 0; c--)
            send_beat(MODE_INPUT, MAT_B, 3'd5, c, rand_value());
        send_beat(MODE_INPUT, MAT_C, 3'd2, 3'd0, 32'h0001_0000);
        send_beat(MODE_COEF, MAT_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_beat(MODE_COEF, MAT_B, 3'd0, 3'd0, 32'h8000_0000);
        send_beat(MODE_COEF, MAT_C, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_beat(MODE_COEF, MAT_D, 3'd0, 3'd0, 32'h0000_8000);
        send_beat(MODE_STATE, MAT_D, 3'd0, 3'd7, 32'h7FFF_FFFF);
        send_beat(MODE_INPUT, MAT_D, 3'd7, 3'd0, 32'h8000_0000);
        send_beat(MODE_CLEAR, MAT_D, 3'd7, 3'd7, 32'hFFFF_FFFF);
        // half-way products round up for both signs
        send_beat(MODE_INPUT, MAT_A, 3'd0, 3'd0, 32'h0000_0001);
        send_beat(MODE_INPUT, MAT_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
        send_beat(MODE_COEF, MAT_A, 3'd7, 3'd7, $urandom);
        send_beat(MODE_COEF, MAT_B, 3'd7, 3'd7, $urandom);
        send_beat(MODE_COEF, MAT_C, 3'd7, 3'd7, $urandom);
        send_beat(MODE_COEF, MAT_D, 3'd7, 3'd7, $urandom);
        send_beat(MODE_STATE, MAT_B, 3'd7, 3'd0, 32'h8000_0000);
        send_beat(MODE_INPUT, MAT_C, 3'd7, 3'd7, rand_value());
        send_beat(MODE_INPUT, MAT_C, 3'd0, 3'd0, 32'h0001_0000);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            cs   = {$urandom, 4'h0} >> 4 << 4;
            ci   = {$urandom, 4'h0} >> 4 << 4;
            co   = {$urandom, 4'h0} >> 4 << 4;
            step = $urandom;
            case (phase)
                0:
                begin
                    cs[3:0] = 4'd8;
                    ci[3:0] = 4'd8;
                    co[3:0] = 4'd8;
                    step    = 32'hFFFF_FFFF;
                end
                1:
                begin
                    step = 32'h0000_0000;
                end
                2:
                begin
                    cs[3:0] = 4'd15;
                    ci[3:0] = 4'd15;
                    co[3:0] = 4'd15;
                    step    = 32'h0001_0000;
                end
                3:
                begin
                    cs[3:0] = $urandom_range(1, 8);
                    ci[3:0] = $urandom_range(1, 8);
                    co[3:0] = $urandom_range(1, 8);
                    step    = $urandom_range(0, 32'h0002_0000);
                end
                default:
                begin
                    cs[3:0] = $urandom_range(0, 15);
                    ci[3:0] = $urandom_range(0, 15);
                    co[3:0] = $urandom_range(0, 15);
                    if ($urandom_range(1) == 0)
                        step = $urandom_range(0, 32'h0002_0000);
                end
            endcase
            write_cfg(CFG_STATE_COUNT, cs);
            write_cfg(CFG_INPUT_COUNT, ci);
            write_cfg(CFG_OUTPUT_COUNT, co);
            write_cfg(CFG_STEP_SIZE, step);
            case (phase % 4)
                1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
                3:       begin send_idle_pct = 37; recv_stall_pct = 37; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (phase == 4)
                pressure_on = 1'b1;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                run_sequence();
        end

        settle();
        sb.drain_check();
        $display("Covered %0d input beats over %0d configurations: %0d Euler steps,",
                 items_sent, PHASE_COUNT + 1, sb.steps);
        $display("%0d output beats compared, with random stalls and one long hold-off",
                 sb.beats);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
